// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the schedule generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DPSG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dpsg checker: implication failed");

// Next-cycle implication.
`define DPSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dpsg checker: next-cycle implication failed");

`endif

// ===== rtl/dpsg_pkg.sv =====
// Package with types, codes and lookup functions of the pulse schedule generator.
`default_nettype none

package dpsg_pkg;

   // Field and datapath widths.
   localparam int IDX_W         = 8;
   localparam int KIND_W        = 3;
   localparam int COUNT_W       = 8;
   localparam int CNT_W         = COUNT_W + 1;
   localparam int DIV_W         = COUNT_W + 1;
   localparam int REM_W         = DIV_W + 1;
   localparam int CSR_W         = 8;
   localparam int CSR_IDX_W     = 1;
   localparam int MAX_PULSES    = 255;
   localparam int FRAC_BITS_DEF = 16;
   localparam int DIV_STEPS     = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_KIND  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 1'd1;

   // Requested schedule kinds.
   localparam logic [KIND_W-1:0] REQ_AUTO   = 3'd0;
   localparam logic [KIND_W-1:0] REQ_RAMSEY = 3'd1;
   localparam logic [KIND_W-1:0] REQ_HAHN   = 3'd2;
   localparam logic [KIND_W-1:0] REQ_CPMG   = 3'd3;
   localparam logic [KIND_W-1:0] REQ_WAHUHA = 3'd4;

   // Denominators of the fixed schedules and the WAHUHA full-period bound.
   localparam logic [DIV_W-1:0] HAHN_DEN = 9'd2;
   localparam logic [DIV_W-1:0] WH_DEN   = 9'd6;
   localparam logic [2:0]       WH_FULL  = 3'd6;

   typedef enum logic [1:0] {
      KIND_RAMSEY = 2'd0,
      KIND_HAHN   = 2'd1,
      KIND_CPMG   = 2'd2,
      KIND_WAHUHA = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      AXIS_NONE = 2'd0,
      AXIS_X    = 2'd1,
      AXIS_Y    = 2'd2
   } axis_type;

   typedef enum logic [1:0] {
      ANG_0   = 2'd0,
      ANG_90  = 2'd1,
      ANG_180 = 2'd2,
      ANG_270 = 2'd3
   } angle_type;

   // Per-request control that travels beside the division.
   typedef struct packed {
      logic       res_valid;
      kind_type   kind;
      logic       last;
      axis_type   axis;
      angle_type  ang;
      logic [1:0] cls;
      logic       en_one;
   } side_type;

   typedef struct packed {
      logic             bit_q;
      logic [DIV_W-1:0] rem;
   } div_step_type;

   // One restoring division step: double the remainder, subtract if it fits.
   function automatic div_step_type div_step(input logic [DIV_W-1:0] rem,
                                             input logic [DIV_W-1:0] dvs);
      logic [REM_W-1:0] dbl;
      logic [REM_W-1:0] dif;
      div_step_type     res;
      dbl = {rem, 1'b0};
      dif = dbl - {1'b0, dvs};
      if (dbl >= {1'b0, dvs}) begin
         res.bit_q = 1'b1;
         res.rem   = dif[DIV_W-1:0];
      end else begin
         res.bit_q = 1'b0;
         res.rem   = dbl[DIV_W-1:0];
      end
      return res;
   endfunction

   // WAHUHA interval bounds in sixths of the period.
   function automatic logic [2:0] wh_lo(input logic [2:0] i);
      case (i)
         3'd0:    return 3'd0;
         3'd1:    return 3'd1;
         3'd2:    return 3'd2;
         3'd3:    return 3'd4;
         3'd4:    return 3'd5;
         default: return 3'd0;
      endcase
   endfunction

   function automatic logic [2:0] wh_hi(input logic [2:0] i);
      case (i)
         3'd0:    return 3'd1;
         3'd1:    return 3'd2;
         3'd2:    return 3'd4;
         3'd3:    return 3'd5;
         3'd4:    return 3'd6;
         default: return 3'd0;
      endcase
   endfunction

   function automatic axis_type wh_axis(input logic [2:0] i);
      case (i)
         3'd0:    return AXIS_X;
         3'd1:    return AXIS_Y;
         3'd2:    return AXIS_Y;
         3'd3:    return AXIS_X;
         default: return AXIS_NONE;
      endcase
   endfunction

   function automatic angle_type wh_ang(input logic [2:0] i);
      case (i)
         3'd0:    return ANG_90;
         3'd1:    return ANG_270;
         3'd2:    return ANG_90;
         3'd3:    return ANG_270;
         default: return ANG_0;
      endcase
   endfunction

   function automatic logic [1:0] wh_cls(input logic [2:0] i);
      case (i)
         3'd2:    return 2'd2;
         default: return 2'd0;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== rtl/decoupling_pulse_schedule_generator_unit.sv =====
// Top level of the decoupling pulse schedule generator: registers and pipeline.
//
//   Channel   Handshake                   Payload
//   request   start / busy                req_interval_index
//   response  rsp_valid (one-cycle pulse) rsp_valid_res ... rsp_last_interval
//   csr       csr_we                      csr_index, csr_wdata
//
// One request is taken per cycle outside reset; each response passes the decode stage,
// the divider stages and the output register in turn. The restoring divider resolves up
// to four quotient bits per pipeline stage.
// Reset is synchronous; it clears the configuration registers and all stage valid bits, and
// busy is high only while reset is applied. Nothing stalls: responses leave
// in request order without back-pressure.
`default_nettype none

module decoupling_pulse_schedule_generator_unit
   import dpsg_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [IDX_W-1:0]     req_interval_index,
   output logic                      rsp_valid,
   output logic                      rsp_valid_res,
   output logic [FRAC_BITS:0]        rsp_interval_start,
   output logic [FRAC_BITS:0]        rsp_interval_end,
   output logic [FRAC_BITS:0]        rsp_interval_length,
   output logic [1:0]                rsp_pulse_axis,
   output logic [1:0]                rsp_angle_quarters,
   output logic [1:0]                rsp_length_class,
   output logic [1:0]                rsp_resolved_kind,
   output logic                      rsp_last_interval,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int NDIV       = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int LAST_STEPS = FRAC_BITS - DIV_STEPS * (NDIV - 1);

   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               fire;

   logic                 p_valid [NDIV+1];
   side_type             p_side  [NDIV+1];
   logic [DIV_W-1:0]     p_dvs   [NDIV+1];
   logic [DIV_W-1:0]     p_r_st  [NDIV+1];
   logic [DIV_W-1:0]     p_r_en  [NDIV+1];
   logic [FRAC_BITS-1:0] p_q_st  [NDIV+1];
   logic [FRAC_BITS-1:0] p_q_en  [NDIV+1];

   // Requests are refused only while reset is applied.
   assign busy = reset;
   assign fire = start && !busy;

   // Configuration registers.
   always_comb begin
      kind_in  = kind_ff;
      count_in = count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KIND:  kind_in  = csr_wdata[KIND_W-1:0];
            CSR_COUNT: count_in = csr_wdata[COUNT_W-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= REQ_AUTO;
         count_ff <= '0;
      end else begin
         kind_ff  <= kind_in;
         count_ff <= count_in;
      end
   end

   // Kind resolution and dividend setup.
   dpsg_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (fire),
      .in_idx    (req_interval_index),
      .cfg_kind  (kind_ff),
      .cfg_count (count_ff),
      .out_valid (p_valid[0]),
      .out_side  (p_side[0]),
      .out_dvs   (p_dvs[0]),
      .out_a_st  (p_r_st[0]),
      .out_a_en  (p_r_en[0])
   );

   assign p_q_st[0] = '0;
   assign p_q_en[0] = '0;

   // Divider pipeline.
   for (genvar g = 0; g < NDIV; g++) begin : g_div
      localparam int NSTEP = (g == NDIV - 1) ? LAST_STEPS : DIV_STEPS;
      dpsg_div_stage #(
         .Q_W   (FRAC_BITS),
         .NSTEP (NSTEP)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (p_valid[g]),
         .in_side   (p_side[g]),
         .in_dvs    (p_dvs[g]),
         .in_r_st   (p_r_st[g]),
         .in_r_en   (p_r_en[g]),
         .in_q_st   (p_q_st[g]),
         .in_q_en   (p_q_en[g]),
         .out_valid (p_valid[g+1]),
         .out_side  (p_side[g+1]),
         .out_dvs   (p_dvs[g+1]),
         .out_r_st  (p_r_st[g+1]),
         .out_r_en  (p_r_en[g+1]),
         .out_q_st  (p_q_st[g+1]),
         .out_q_en  (p_q_en[g+1])
      );
   end

   // Response formation.
   dpsg_out #(
      .FRAC_BITS (FRAC_BITS)
   ) u_out (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (p_valid[NDIV]),
      .in_side             (p_side[NDIV]),
      .in_q_st             (p_q_st[NDIV]),
      .in_q_en             (p_q_en[NDIV]),
      .rsp_valid           (rsp_valid),
      .rsp_valid_res       (rsp_valid_res),
      .rsp_interval_start  (rsp_interval_start),
      .rsp_interval_end    (rsp_interval_end),
      .rsp_interval_length (rsp_interval_length),
      .rsp_pulse_axis      (rsp_pulse_axis),
      .rsp_angle_quarters  (rsp_angle_quarters),
      .rsp_length_class    (rsp_length_class),
      .rsp_resolved_kind   (rsp_resolved_kind),
      .rsp_last_interval   (rsp_last_interval)
   );

endmodule

`default_nettype wire

// ===== rtl/dpsg_decode.sv =====
// First pipeline stage: resolves the schedule kind and sets up the bound divisions.
`default_nettype none

module dpsg_decode
   import dpsg_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_fire,
   input  wire logic [IDX_W-1:0]     in_idx,
   input  wire logic [KIND_W-1:0]    cfg_kind,
   input  wire logic [COUNT_W-1:0]   cfg_count,
   output logic                      out_valid,
   output side_type                  out_side,
   output logic [DIV_W-1:0]          out_dvs,
   output logic [DIV_W-1:0]          out_a_st,
   output logic [DIV_W-1:0]          out_a_en
);

   logic             valid_ff;
   side_type         side_ff, side_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W-1:0] a_st_ff, a_st_in;
   logic [DIV_W-1:0] a_en_ff, a_en_in;

   // Resolve the kind, range-check the index and pick each bound's dividend.
   always_comb begin
      logic [COUNT_W-1:0] n_sat;
      logic [CNT_W-1:0]   cnt;
      logic               in_range;
      logic [2:0]         hi;
      side_in = '0;
      dvs_in  = HAHN_DEN;
      a_st_in = '0;
      a_en_in = '0;
      hi      = wh_hi(in_idx[2:0]);
      if (int'(cfg_count) > MAX_PULSES) begin
         n_sat = COUNT_W'(MAX_PULSES);
      end else begin
         n_sat = cfg_count;
      end
      if (cfg_kind == REQ_WAHUHA) begin
         side_in.kind = KIND_WAHUHA;
         cnt          = CNT_W'(5);
      end else if (n_sat == '0 || cfg_kind == REQ_RAMSEY) begin
         side_in.kind = KIND_RAMSEY;
         cnt          = CNT_W'(1);
      end else if (n_sat == COUNT_W'(1) || cfg_kind == REQ_HAHN) begin
         side_in.kind = KIND_HAHN;
         cnt          = CNT_W'(2);
      end else begin
         side_in.kind = KIND_CPMG;
         cnt          = {1'b0, n_sat} + CNT_W'(1);
      end
      in_range          = {1'b0, in_idx} < cnt;
      side_in.res_valid = in_range;
      side_in.last      = in_range && ({1'b0, in_idx} == cnt - CNT_W'(1));
      case (side_in.kind)
         KIND_RAMSEY: begin
            side_in.en_one = 1'b1;
         end
         KIND_HAHN: begin
            if (in_idx == '0) begin
               a_en_in      = DIV_W'(1);
               side_in.axis = AXIS_X;
               side_in.ang  = ANG_180;
            end else begin
               a_st_in        = DIV_W'(1);
               side_in.en_one = 1'b1;
            end
         end
         KIND_WAHUHA: begin
            dvs_in       = WH_DEN;
            a_st_in      = DIV_W'(wh_lo(in_idx[2:0]));
            side_in.axis = wh_axis(in_idx[2:0]);
            side_in.ang  = wh_ang(in_idx[2:0]);
            side_in.cls  = wh_cls(in_idx[2:0]);
            if (hi == WH_FULL) begin
               side_in.en_one = 1'b1;
            end else begin
               a_en_in = DIV_W'(hi);
            end
         end
         KIND_CPMG: begin
            // Boundaries sit at odd multiples of 1/(2n).
            dvs_in = {n_sat, 1'b0};
            if (in_idx != '0) begin
               a_st_in = {in_idx, 1'b0} - DIV_W'(1);
            end
            if (in_idx == n_sat) begin
               side_in.en_one = 1'b1;
            end else begin
               a_en_in      = {in_idx, 1'b1};
               side_in.axis = AXIS_X;
               side_in.ang  = ANG_180;
            end
            side_in.cls = (in_idx == '0 || in_idx == n_sat) ? 2'd0 : 2'd1;
         end
         default: begin
            side_in.en_one = 1'b1;
         end
      endcase
      // Out-of-range requests carry only the kind.
      if (!in_range) begin
         a_st_in        = '0;
         a_en_in        = '0;
         side_in.axis   = AXIS_NONE;
         side_in.ang    = ANG_0;
         side_in.cls    = 2'd0;
         side_in.en_one = 1'b0;
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_fire;
      end
      side_ff <= side_in;
      dvs_ff  <= dvs_in;
      a_st_ff <= a_st_in;
      a_en_ff <= a_en_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_dvs   = dvs_ff;
   assign out_a_st  = a_st_ff;
   assign out_a_en  = a_en_ff;

endmodule

`default_nettype wire

// ===== rtl/dpsg_div_stage.sv =====
// One stage of the restoring divider: NSTEP quotient bits for both bounds.
`default_nettype none

module dpsg_div_stage
   import dpsg_pkg::*;
#(
   parameter int Q_W   = FRAC_BITS_DEF,
   parameter int NSTEP = DIV_STEPS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire side_type         in_side,
   input  wire logic [DIV_W-1:0] in_dvs,
   input  wire logic [DIV_W-1:0] in_r_st,
   input  wire logic [DIV_W-1:0] in_r_en,
   input  wire logic [Q_W-1:0]   in_q_st,
   input  wire logic [Q_W-1:0]   in_q_en,
   output logic                  out_valid,
   output side_type              out_side,
   output logic [DIV_W-1:0]      out_dvs,
   output logic [DIV_W-1:0]      out_r_st,
   output logic [DIV_W-1:0]      out_r_en,
   output logic [Q_W-1:0]        out_q_st,
   output logic [Q_W-1:0]        out_q_en
);

   logic             valid_ff;
   side_type         side_ff;
   logic [DIV_W-1:0] dvs_ff;
   logic [DIV_W-1:0] r_st_ff, r_st_in;
   logic [DIV_W-1:0] r_en_ff, r_en_in;
   logic [Q_W-1:0]   q_st_ff, q_st_in;
   logic [Q_W-1:0]   q_en_ff, q_en_in;

   // NSTEP dependent steps on the narrow remainders, both lanes side by side.
   always_comb begin
      div_step_type s_st;
      div_step_type s_en;
      r_st_in = in_r_st;
      r_en_in = in_r_en;
      q_st_in = in_q_st;
      q_en_in = in_q_en;
      for (int k = 0; k < NSTEP; k++) begin
         s_st    = div_step(r_st_in, in_dvs);
         s_en    = div_step(r_en_in, in_dvs);
         r_st_in = s_st.rem;
         r_en_in = s_en.rem;
         q_st_in = {q_st_in[Q_W-2:0], s_st.bit_q};
         q_en_in = {q_en_in[Q_W-2:0], s_en.bit_q};
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      side_ff <= in_side;
      dvs_ff  <= in_dvs;
      r_st_ff <= r_st_in;
      r_en_ff <= r_en_in;
      q_st_ff <= q_st_in;
      q_en_ff <= q_en_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_dvs   = dvs_ff;
   assign out_r_st  = r_st_ff;
   assign out_r_en  = r_en_ff;
   assign out_q_st  = q_st_ff;
   assign out_q_en  = q_en_ff;

endmodule

`default_nettype wire

// ===== rtl/dpsg_out.sv =====
// Last pipeline stage: forms start, end and length and registers the response.
`default_nettype none

module dpsg_out
   import dpsg_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire side_type             in_side,
   input  wire logic [FRAC_BITS-1:0] in_q_st,
   input  wire logic [FRAC_BITS-1:0] in_q_en,
   output logic                      rsp_valid,
   output logic                      rsp_valid_res,
   output logic [FRAC_BITS:0]        rsp_interval_start,
   output logic [FRAC_BITS:0]        rsp_interval_end,
   output logic [FRAC_BITS:0]        rsp_interval_length,
   output logic [1:0]                rsp_pulse_axis,
   output logic [1:0]                rsp_angle_quarters,
   output logic [1:0]                rsp_length_class,
   output logic [1:0]                rsp_resolved_kind,
   output logic                      rsp_last_interval
);

   localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

   logic                 valid_ff;
   logic                 res_ff, res_in;
   logic [FRAC_BITS:0]   st_ff, st_in;
   logic [FRAC_BITS:0]   en_ff, en_in;
   logic [FRAC_BITS:0]   len_ff, len_in;
   logic [1:0]           axis_ff, axis_in;
   logic [1:0]           ang_ff, ang_in;
   logic [1:0]           cls_ff, cls_in;
   logic [1:0]           kind_ff;
   logic                 last_ff, last_in;

   // Full-period end replaces the quotient; invalid requests give zeros.
   always_comb begin
      res_in  = in_side.res_valid;
      st_in   = {1'b0, in_q_st};
      en_in   = in_side.en_one ? ONE_FX : {1'b0, in_q_en};
      len_in  = en_in - st_in;
      axis_in = in_side.axis;
      ang_in  = in_side.ang;
      cls_in  = in_side.cls;
      last_in = in_side.last;
      if (!res_in) begin
         st_in   = '0;
         en_in   = '0;
         len_in  = '0;
         axis_in = '0;
         ang_in  = '0;
         cls_in  = '0;
         last_in = 1'b0;
      end
   end

   // Response register; the strobe lasts one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      res_ff  <= res_in;
      st_ff   <= st_in;
      en_ff   <= en_in;
      len_ff  <= len_in;
      axis_ff <= axis_in;
      ang_ff  <= ang_in;
      cls_ff  <= cls_in;
      kind_ff <= in_side.kind;
      last_ff <= last_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_valid_res       = res_ff;
   assign rsp_interval_start  = st_ff;
   assign rsp_interval_end    = en_ff;
   assign rsp_interval_length = len_ff;
   assign rsp_pulse_axis      = axis_ff;
   assign rsp_angle_quarters  = ang_ff;
   assign rsp_length_class    = cls_ff;
   assign rsp_resolved_kind   = kind_ff;
   assign rsp_last_interval   = last_ff;

endmodule

`default_nettype wire

// ===== rtl/dpsg_checker.sv =====
// Port-level checker of the schedule generator and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module dpsg_checker
   import dpsg_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire logic [IDX_W-1:0]     req_interval_index,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_valid_res,
   input wire logic [FRAC_BITS:0]   rsp_interval_start,
   input wire logic [FRAC_BITS:0]   rsp_interval_end,
   input wire logic [FRAC_BITS:0]   rsp_interval_length,
   input wire logic [1:0]           rsp_pulse_axis,
   input wire logic [1:0]           rsp_angle_quarters,
   input wire logic [1:0]           rsp_length_class,
   input wire logic                 rsp_last_interval
);

   localparam int LAT = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS + 2;
   localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

   // Every response goes back to an earlier request that was taken while not busy.
   `DPSG_ASSERT_IMP(a_rsp_has_request, clock, reset, rsp_valid, $past(start && !busy, LAT))

   // The first interval of any schedule starts at zero.
   `DPSG_ASSERT_IMP(a_first_starts_zero, clock, reset,
      rsp_valid && rsp_valid_res && $past(req_interval_index, LAT) == '0,
      rsp_interval_start == '0)

   // The final interval reaches the full period and no pulse closes it.
   `DPSG_ASSERT_IMP(a_last_full_period, clock, reset,
      rsp_valid && rsp_valid_res && rsp_last_interval,
      rsp_interval_end == ONE_FX && rsp_pulse_axis == AXIS_NONE)

   // An index beyond the schedule gives an all-zero interval.
   `DPSG_ASSERT_IMP(a_invalid_zero, clock, reset, rsp_valid && !rsp_valid_res,
      rsp_interval_start == '0 && rsp_interval_end == '0 &&
      rsp_interval_length == '0 && rsp_pulse_axis == '0 &&
      rsp_angle_quarters == '0 && rsp_length_class == '0 && !rsp_last_interval)

   // Reset flushes the pipeline, so no strobe follows a reset cycle.
   `DPSG_ASSERT_NEXT(a_reset_flush, clock, 1'b0, reset, !rsp_valid)

endmodule

bind decoupling_pulse_schedule_generator_unit dpsg_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_dpsg_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_interval_index  (req_interval_index),
   .rsp_valid           (rsp_valid),
   .rsp_valid_res       (rsp_valid_res),
   .rsp_interval_start  (rsp_interval_start),
   .rsp_interval_end    (rsp_interval_end),
   .rsp_interval_length (rsp_interval_length),
   .rsp_pulse_axis      (rsp_pulse_axis),
   .rsp_angle_quarters  (rsp_angle_quarters),
   .rsp_length_class    (rsp_length_class),
   .rsp_last_interval   (rsp_last_interval)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the decoupling pulse schedule generator unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dpsg_pkg::*;

   localparam int             FRAC       = FRAC_BITS_DEF;
   localparam logic [63:0]    ONE_FX     = 64'd1 << FRAC;
   localparam int             NUM_ROWS   = 24;
   localparam int             NUM_PHASES = 28;
   localparam int             PHASE_REQS = 25;
   localparam int             LATENCY    = 8;

   // Kind codes without a schedule of their own; the count decides the kind.
   localparam logic [KIND_W-1:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [KIND_W-1:0] REQ_UNUSED_HI = 3'd7;

   // One schedule interval as the unit reports it.
   typedef struct packed {
      logic             valid_res;
      logic [FRAC:0]    start_fx;
      logic [FRAC:0]    end_fx;
      logic [FRAC:0]    length_fx;
      axis_type         axis;
      angle_type        angle;
      logic [1:0]       cls;
      kind_type         kind;
      logic             last;
   } sched_interval_type;

   // One directed request with the settings it runs under.
   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [COUNT_W-1:0] count;
      logic [IDX_W-1:0]   idx;
      bit                 typed;
      sched_interval_type want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic [IDX_W-1:0]      req_interval_index = '0;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_KIND;
   logic [CSR_W-1:0]      csr_wdata = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic                  rsp_valid_res;
   logic [FRAC:0]         rsp_interval_start;
   logic [FRAC:0]         rsp_interval_end;
   logic [FRAC:0]         rsp_interval_length;
   logic [1:0]            rsp_pulse_axis;
   logic [1:0]            rsp_angle_quarters;
   logic [1:0]            rsp_length_class;
   logic [1:0]            rsp_resolved_kind;
   logic                  rsp_last_interval;

   // Shadow copies of the two registers.
   logic [KIND_W-1:0]     cfg_kind  = REQ_AUTO;
   logic [COUNT_W-1:0]    cfg_count = '0;

   sched_interval_type    pending_intervals[$];
   int                    mismatch_count = 0;
   int                    idle_pct = 14;

   // Directed requests: extremes, every kind, out-of-range indexes, unused codes.
   stim_row_type directed_rows [NUM_ROWS] = '{
      '{REQ_AUTO, 8'd0, 8'd0, 1'b1,
        '{1'b1, 17'd0, 17'd65536, 17'd65536, AXIS_NONE, ANG_0, 2'd0, KIND_RAMSEY, 1'b1}},
      '{REQ_AUTO, 8'd0, 8'd255, 1'b1,
        '{1'b0, 17'd0, 17'd0, 17'd0, AXIS_NONE, ANG_0, 2'd0, KIND_RAMSEY, 1'b0}},
      '{REQ_RAMSEY, 8'd200, 8'd0, 1'b1,
        '{1'b1, 17'd0, 17'd65536, 17'd65536, AXIS_NONE, ANG_0, 2'd0, KIND_RAMSEY, 1'b1}},
      '{REQ_RAMSEY, 8'd200, 8'd1, 1'b0, '0},
      '{REQ_AUTO, 8'd1, 8'd0, 1'b1,
        '{1'b1, 17'd0, 17'd32768, 17'd32768, AXIS_X, ANG_180, 2'd0, KIND_HAHN, 1'b0}},
      '{REQ_AUTO, 8'd1, 8'd1, 1'b1,
        '{1'b1, 17'd32768, 17'd65536, 17'd32768, AXIS_NONE, ANG_0, 2'd0, KIND_HAHN, 1'b1}},
      '{REQ_HAHN, 8'd255, 8'd2, 1'b1,
        '{1'b0, 17'd0, 17'd0, 17'd0, AXIS_NONE, ANG_0, 2'd0, KIND_HAHN, 1'b0}},
      '{REQ_CPMG, 8'd0, 8'd0, 1'b0, '0},
      '{REQ_CPMG, 8'd1, 8'd1, 1'b0, '0},
      '{REQ_AUTO, 8'd2, 8'd0, 1'b0, '0},
      '{REQ_AUTO, 8'd2, 8'd1, 1'b0, '0},
      '{REQ_AUTO, 8'd2, 8'd2, 1'b0, '0},
      '{REQ_AUTO, 8'd2, 8'd3, 1'b0, '0},
      '{REQ_WAHUHA, 8'd0, 8'd0, 1'b0, '0},
      '{REQ_WAHUHA, 8'd0, 8'd1, 1'b0, '0},
      '{REQ_WAHUHA, 8'd0, 8'd2, 1'b0, '0},
      '{REQ_WAHUHA, 8'd0, 8'd3, 1'b0, '0},
      '{REQ_WAHUHA, 8'd255, 8'd4, 1'b1,
        '{1'b1, 17'd54613, 17'd65536, 17'd10923, AXIS_NONE, ANG_0, 2'd0, KIND_WAHUHA, 1'b1}},
      '{REQ_WAHUHA, 8'd255, 8'd5, 1'b1,
        '{1'b0, 17'd0, 17'd0, 17'd0, AXIS_NONE, ANG_0, 2'd0, KIND_WAHUHA, 1'b0}},
      '{REQ_UNUSED_LO, 8'd2, 8'd1, 1'b0, '0},
      '{REQ_UNUSED_HI, 8'd0, 8'd0, 1'b0, '0},
      '{REQ_CPMG, 8'd255, 8'd0, 1'b1,
        '{1'b1, 17'd0, 17'd128, 17'd128, AXIS_X, ANG_180, 2'd0, KIND_CPMG, 1'b0}},
      '{REQ_CPMG, 8'd255, 8'd254, 1'b0, '0},
      '{REQ_CPMG, 8'd255, 8'd255, 1'b1,
        '{1'b1, 17'd65407, 17'd65536, 17'd129, AXIS_NONE, ANG_0, 2'd0, KIND_CPMG, 1'b1}}
   };

   decoupling_pulse_schedule_generator_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_interval_index  (req_interval_index),
      .rsp_valid           (rsp_valid),
      .rsp_valid_res       (rsp_valid_res),
      .rsp_interval_start  (rsp_interval_start),
      .rsp_interval_end    (rsp_interval_end),
      .rsp_interval_length (rsp_interval_length),
      .rsp_pulse_axis      (rsp_pulse_axis),
      .rsp_angle_quarters  (rsp_angle_quarters),
      .rsp_length_class    (rsp_length_class),
      .rsp_resolved_kind   (rsp_resolved_kind),
      .rsp_last_interval   (rsp_last_interval),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Computes the interval that the unit should return for one index.
   function automatic sched_interval_type schedule_interval(
      input logic [KIND_W-1:0] kind_reg,
      input logic [COUNT_W-1:0] count_reg,
      input logic [IDX_W-1:0] idx);
      sched_interval_type r;
      logic [63:0]     n;
      logic [63:0]     i;
      logic [63:0]     total;
      logic [63:0]     st;
      logic [63:0]     en;
      logic [63:0]     lo_six;
      logic [63:0]     hi_six;
      r      = '0;
      n      = 64'(count_reg);
      i      = 64'(idx);
      st     = '0;
      en     = '0;
      lo_six = '0;
      hi_six = '0;
      // The named WAHUHA wins, then Ramsey, then Hahn echo, and CPMG last.
      if (kind_reg == REQ_WAHUHA) begin
         r.kind = KIND_WAHUHA;
         total  = 64'd5;
      end else if (n == 0 || kind_reg == REQ_RAMSEY) begin
         r.kind = KIND_RAMSEY;
         total  = 64'd1;
      end else if (n == 1 || kind_reg == REQ_HAHN) begin
         r.kind = KIND_HAHN;
         total  = 64'd2;
      end else begin
         r.kind = KIND_CPMG;
         total  = n + 64'd1;
      end
      if (i >= total) begin
         return r;
      end
      r.valid_res = 1'b1;
      r.last      = (i == total - 64'd1);
      case (r.kind)
         KIND_RAMSEY: begin
            st = 64'd0;
            en = ONE_FX;
         end
         KIND_HAHN: begin
            if (i == 0) begin
               en      = ONE_FX >> 1;
               r.axis  = AXIS_X;
               r.angle = ANG_180;
            end else begin
               st = ONE_FX >> 1;
               en = ONE_FX;
            end
         end
         KIND_WAHUHA: begin
            // Bounds in sixths of the period; the long middle window is its own class.
            case (i)
               64'd0: begin
                  lo_six = 0; hi_six = 1; r.axis = AXIS_X; r.angle = ANG_90;
               end
               64'd1: begin
                  lo_six = 1; hi_six = 2; r.axis = AXIS_Y; r.angle = ANG_270;
               end
               64'd2: begin
                  lo_six = 2; hi_six = 4; r.axis = AXIS_Y; r.angle = ANG_90; r.cls = 2'd2;
               end
               64'd3: begin
                  lo_six = 4; hi_six = 5; r.axis = AXIS_X; r.angle = ANG_270;
               end
               default: begin
                  lo_six = 5; hi_six = 6;
               end
            endcase
            st = (lo_six * ONE_FX) / 64'd6;
            en = (hi_six * ONE_FX) / 64'd6;
         end
         default: begin
            // CPMG boundaries sit at (2c-1)/(2n); no pulse closes the final window.
            st = (i == 0) ? 64'd0 : ((2 * i - 1) * ONE_FX) / (2 * n);
            en = (i == n) ? ONE_FX : ((2 * i + 1) * ONE_FX) / (2 * n);
            if (i != n) begin
               r.axis  = AXIS_X;
               r.angle = ANG_180;
            end
            r.cls = (i == 0 || i == n) ? 2'd0 : 2'd1;
         end
      endcase
      r.start_fx  = st[FRAC:0];
      r.end_fx    = en[FRAC:0];
      r.length_fx = 17'(en - st);
      return r;
   endfunction

   // Reports one field that differs from its expected value.
   task automatic check_field(input string name, input logic [63:0] want_v,
                              input logic [63:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   // Writes one register at a falling edge and keeps the shadow copy in step.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == CSR_KIND) begin
         cfg_kind = data[KIND_W-1:0];
      end else begin
         cfg_count = data[COUNT_W-1:0];
      end
   endtask

   // Lowers start and waits until every outstanding response has come back.
   task automatic drain_responses();
      @(negedge clock);
      start <= 1'b0;
      while (pending_intervals.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Brings both registers to new values while nothing is in flight.
   task automatic set_schedule(input logic [KIND_W-1:0] kind, input logic [COUNT_W-1:0] count);
      drain_responses();
      write_csr(CSR_KIND, CSR_W'(kind));
      write_csr(CSR_COUNT, count);
   endtask

   // Drives one request, with random idle cycles ahead of it, and records its result.
   task automatic issue_request(input logic [IDX_W-1:0] idx, input sched_interval_type want);
      @(negedge clock);
      while ($urandom_range(1, 100) <= idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start              <= 1'b1;
      req_interval_index <= idx;
      do begin
         @(posedge clock);
      end while (busy);
      pending_intervals.push_back(want);
   endtask

   // Response checker: each strobe is matched against the oldest expected interval.
   always @(posedge clock) begin
      sched_interval_type got;
      sched_interval_type want;
      if (!reset && rsp_valid) begin
         got.valid_res = rsp_valid_res;
         got.start_fx  = rsp_interval_start;
         got.end_fx    = rsp_interval_end;
         got.length_fx = rsp_interval_length;
         got.axis      = axis_type'(rsp_pulse_axis);
         got.angle     = angle_type'(rsp_angle_quarters);
         got.cls       = rsp_length_class;
         got.kind      = kind_type'(rsp_resolved_kind);
         got.last      = rsp_last_interval;
         if (pending_intervals.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_intervals.pop_front();
            check_field("valid_res", 64'(want.valid_res), 64'(got.valid_res));
            check_field("interval_start", 64'(want.start_fx), 64'(got.start_fx));
            check_field("interval_end", 64'(want.end_fx), 64'(got.end_fx));
            check_field("interval_length", 64'(want.length_fx), 64'(got.length_fx));
            check_field("pulse_axis", 64'(want.axis), 64'(got.axis));
            check_field("angle_quarters", 64'(want.angle), 64'(got.angle));
            check_field("length_class", 64'(want.cls), 64'(got.cls));
            check_field("resolved_kind", 64'(want.kind), 64'(got.kind));
            check_field("last_interval", 64'(want.last), 64'(got.last));
         end
      end
   end

   // Main sequence: reset, directed table, then random phases under new settings.
   initial begin
      int                  span;
      logic [KIND_W-1:0]   kind;
      logic [COUNT_W-1:0]  count;
      logic [IDX_W-1:0]    idx;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part; rows with a typed result use it, the rest use the predictor.
      idle_pct = 14;
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind != cfg_kind || directed_rows[r].count != cfg_count) begin
            set_schedule(directed_rows[r].kind, directed_rows[r].count);
         end
         issue_request(directed_rows[r].idx,
                       directed_rows[r].typed ? directed_rows[r].want :
                       schedule_interval(cfg_kind, cfg_count, directed_rows[r].idx));
      end

      // Random part: sender idling changes by thirds, the unit is drained each phase.
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p < NUM_PHASES / 3) begin
            idle_pct = 14;
         end else if (p < 2 * NUM_PHASES / 3) begin
            idle_pct = 51;
         end else begin
            idle_pct = 0;
         end
         kind = 3'($urandom_range(REQ_AUTO, REQ_UNUSED_HI));
         case ($urandom_range(0, 3))
            0: count = 8'($urandom_range(0, 3));
            1: count = 8'd255;
            2: count = 8'($urandom_range(0, 255));
            default: count = 8'($urandom_range(2, 12));
         endcase
         if (p == 0) begin
            kind  = REQ_AUTO;
            count = 8'd255;
         end else if (p == 1) begin
            kind  = REQ_UNUSED_HI;
            count = 8'd0;
         end
         set_schedule(kind, count);
         // Most indexes fall at or below the count plus two, or at or below six for WAHUHA.
         span = (cfg_kind == REQ_WAHUHA) ? 6 : int'(cfg_count) + 2;
         if (span > 255) begin
            span = 255;
         end
         for (int k = 0; k < PHASE_REQS; k++) begin
            if ($urandom_range(1, 100) <= 80) begin
               idx = 8'($urandom_range(0, span));
            end else begin
               idx = 8'($urandom_range(0, 255));
            end
            issue_request(idx, schedule_interval(cfg_kind, cfg_count, idx));
         end
      end

      drain_responses();
      repeat (LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("decoupling_pulse_schedule_generator_unit regression: pass");
      end else begin
         $display("decoupling_pulse_schedule_generator_unit regression: fail");
      end
      $finish;
   end

   // Watchdog for a hung handshake or missing responses.
   initial begin
      #2_000_000;
      $display("decoupling_pulse_schedule_generator_unit regression: fail");
      $finish;
   end

endmodule
